// File: src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the Base64 stream decoder
// Token kinds passed from the character classifier to the decode engine.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharPad   = 8'h3D; // '='
  localparam logic [7:0] CharPlus  = 8'h2B; // '+'
  localparam logic [7:0] CharMinus = 8'h2D; // '-'
  localparam logic [7:0] CharSlash = 8'h2F; // '/'
  localparam logic [7:0] CharUnder = 8'h5F; // '_'
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadChar = 2'd1;
  localparam logic [1:0] StatusLimit   = 2'd2;

  typedef enum logic [1:0] {
    TokValue,
    TokSkip,
    TokPad,
    TokBad
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [5:0] value;
    logic       last;
  } tok_t;

endpackage

// File: src/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: character classifier
// Map one input character to a token: six-bit value, skip, pad or invalid.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
  input  logic [7:0] data_char_i,
  input  logic       last_char_i,
  output tok_t       tok_o
);

  always_comb begin
    tok_o.kind  = TokBad;
    tok_o.value = 6'd0;
    tok_o.last  = last_char_i;
    if (data_char_i >= 8'h41 && data_char_i <= 8'h5A) begin
      tok_o.kind  = TokValue;
      tok_o.value = 6'(data_char_i - 8'h41);
    end else if (data_char_i >= 8'h61 && data_char_i <= 8'h7A) begin
      tok_o.kind  = TokValue;
      tok_o.value = 6'(data_char_i - 8'h61 + 8'd26);
    end else if (data_char_i >= 8'h30 && data_char_i <= 8'h39) begin
      tok_o.kind  = TokValue;
      tok_o.value = 6'(data_char_i - 8'h30 + 8'd52);
    end else if (data_char_i == CharPlus || data_char_i == CharMinus) begin
      tok_o.kind  = TokValue;
      tok_o.value = 6'd62;
    end else if (data_char_i == CharSlash || data_char_i == CharUnder) begin
      tok_o.kind  = TokValue;
      tok_o.value = 6'd63;
    end else if (data_char_i == CharPad) begin
      tok_o.kind  = TokPad;
    end else if (data_char_i == CharSpace || data_char_i == CharTab ||
                 data_char_i == CharCr    || data_char_i == CharLf) begin
      tok_o.kind  = TokSkip;
    end
  end

endmodule

// File: src/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo: token queue
// Short queue between classifier and decode engine.
// ----------------------------------------------------------------------------
module b64d_fifo import b64d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tok_t push_tok_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output tok_t pop_tok_o
);

  localparam int unsigned PtrWidth = $clog2(QueueDepth);

  tok_t                mem_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrWidth:0]   count_q;

  logic do_push, do_pop;

  assign full_o    = (count_q == (PtrWidth+1)'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_tok_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PtrWidth+1)'(do_push) - (PtrWidth+1)'(do_pop);
    end
  end

endmodule

// File: src/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: decode engine
// Collect six-bit values into bytes, track limit and errors, register result.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CountWidth-1:0] limit_i,
  input  logic                  tok_avail_i,
  input  tok_t                  tok_i,
  output logic                  tok_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  byte_valid_o,
  output logic                  frame_done_o,
  output logic [1:0]            status_o,
  output logic [CountWidth-1:0] byte_count_o
);

  logic [5:0]            lbits_q, lbits_d;
  logic [2:0]            lcnt_q, lcnt_d;
  logic [CountWidth-1:0] bytes_q, bytes_d;
  logic                  halted_q, halted_d;
  logic [1:0]            err_q, err_d;

  logic                  out_valid_q;
  logic [7:0]            out_byte_q, out_byte_d;
  logic                  byte_valid_q, byte_valid_d;
  logic                  frame_done_q;
  logic [1:0]            status_q;
  logic [CountWidth-1:0] count_q;

  logic [11:0] acc;
  logic [3:0]  cnt;
  logic [2:0]  cnt_base;
  logic [11:0] shifted;

  assign tok_pop_o = tok_avail_i && (!out_valid_q || out_ready_i);

  always_comb begin
    lbits_d      = lbits_q;
    lcnt_d       = lcnt_q;
    bytes_d      = bytes_q;
    halted_d     = halted_q;
    err_d        = err_q;
    out_byte_d   = 8'd0;
    byte_valid_d = 1'b0;
    acc          = {lbits_q, tok_i.value};
    cnt_base     = (lcnt_q > 3'd6) ? 3'd6 : lcnt_q;
    cnt          = 4'(cnt_base) + 4'd6;
    shifted      = '0;
    if (!halted_q) begin
      unique case (tok_i.kind)
        TokPad: begin
          halted_d = 1'b1;
        end
        TokSkip: begin
        end
        TokBad: begin
          err_d    = StatusBadChar;
          halted_d = 1'b1;
        end
        TokValue: begin
          if (cnt >= 4'd8) begin
            cnt = cnt - 4'd8;
            if (bytes_q >= limit_i || bytes_q == {CountWidth{1'b1}}) begin
              err_d    = StatusLimit;
              halted_d = 1'b1;
            end else begin
              shifted      = acc >> cnt;
              out_byte_d   = shifted[7:0];
              byte_valid_d = 1'b1;
              bytes_d      = bytes_q + 1'b1;
            end
          end
          lbits_d = acc[5:0] & ((6'd1 << cnt) - 6'd1);
          lcnt_d  = cnt[2:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbits_q     <= '0;
      lcnt_q      <= '0;
      bytes_q     <= '0;
      halted_q    <= 1'b0;
      err_q       <= StatusOk;
      out_valid_q <= 1'b0;
    end else begin
      if (tok_pop_o) begin
        out_valid_q <= 1'b1;
        if (tok_i.last) begin
          // message ends: clear everything for the next one
          lbits_q  <= '0;
          lcnt_q   <= '0;
          bytes_q  <= '0;
          halted_q <= 1'b0;
          err_q    <= StatusOk;
        end else begin
          lbits_q  <= lbits_d;
          lcnt_q   <= lcnt_d;
          bytes_q  <= bytes_d;
          halted_q <= halted_d;
          err_q    <= err_d;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      frame_done_q <= tok_i.last;
      status_q     <= err_d;
      count_q      <= bytes_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign frame_done_o = frame_done_q;
  assign status_o     = status_q;
  assign byte_count_o = count_q;

endmodule

// File: src/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming Base64 decoder, one character per item
// Path: an accepted input item is queued, then decoded into a registered result item.
// Throughput: one item per cycle while the receiver keeps taking results.
// Reset: rst_ni clears message state, queue and output; output_limit -> 65535.
// ----------------------------------------------------------------------------
module base64_stream_decoder import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: output_limit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // input characters
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_char
  input  logic        s_axis_tlast_i,   // last_char
  // decoded results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] out_byte, [9:8] status,
                                        // [25:10] byte_count, rest zero
  output logic        m_axis_tuser_o,   // byte_valid
  output logic        m_axis_tlast_o    // frame_done
);

  // Output byte limit per message; the user writes it only while the block is idle (not enforced here).
  logic [CountWidth-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= {CountWidth{1'b1}};
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Front: classify the character as it arrives and push it into the queue.
  tok_t front_tok;
  tok_t queue_tok;
  logic queue_full, queue_empty, queue_pop;

  b64d_front u_front (
    .data_char_i (s_axis_tdata_i),
    .last_char_i (s_axis_tlast_i),
    .tok_o       (front_tok)
  );

  assign s_axis_tready_o = !queue_full;

  b64d_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid_i),
    .push_tok_i (front_tok),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .empty_o    (queue_empty),
    .pop_tok_o  (queue_tok)
  );

  // Back: advance the decode state and hold the result until it is taken.
  logic [7:0]            out_byte;
  logic [1:0]            status;
  logic [CountWidth-1:0] byte_count;

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit_q),
    .tok_avail_i  (!queue_empty),
    .tok_i        (queue_tok),
    .tok_pop_o    (queue_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (out_byte),
    .byte_valid_o (m_axis_tuser_o),
    .frame_done_o (m_axis_tlast_o),
    .status_o     (status),
    .byte_count_o (byte_count)
  );

  assign m_axis_tdata_o = {6'd0, byte_count, status, out_byte};

endmodule

// File: test/base64_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb: self-checking bench for the Base64 stream decoder
// Feed character items through a queue-fed driver with random gaps and check
// every result item against a cycle-free decode of the same characters.
// Cover both alphabets, whitespace, padding, bad characters, output-limit
// overflow and a range of output_limit settings, with back-pressure.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb import b64d_pkg::*; ();

  localparam int unsigned SinkHoldCycles = 120;
  localparam int unsigned CharTarget     = 1900;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        frame_done;
    logic [1:0]  status;
    logic [15:0] byte_count;
  } decode_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;  // [7:0] data_char
  logic        s_axis_tlast_i = 1'b0; // last_char
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [7:0] out_byte, [9:8] status, [25:10] byte_count
  logic        m_axis_tuser_o;        // byte_valid
  logic        m_axis_tlast_o;        // frame_done

  base64_stream_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Characters waiting for the driver, and decoded results waiting for the DUT
  char_item_t     char_q[$];
  decode_result_t decoded_q[$];

  // Decoder state mirrored by the bench
  logic [15:0] limit_reg   = 16'hFFFF;
  logic [5:0]  dec_bits    = '0;
  logic [2:0]  dec_nbits   = '0;
  logic [15:0] dec_emitted = '0;
  logic        dec_halted  = 1'b0;
  logic [1:0]  dec_status  = StatusOk;

  int unsigned sent_chars = 0;  // characters taken by the DUT
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = 30;
  int unsigned sink_idle_pct = 30;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  logic        sink_hold = 1'b0;
  event        sink_hold_go;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Map one character to its six-bit value; 64 flags a non-alphabet character.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
    if (c == CharPlus || c == CharMinus) return 7'd62;
    if (c == CharSlash || c == CharUnder) return 7'd63;
    return 7'd64;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] v, input bit url);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return url ? CharMinus : CharPlus;
    return url ? CharUnder : CharSlash;
  endfunction

  // Advance the mirrored decoder by one accepted character and queue its result.
  function automatic void decode_char(input logic [7:0] c, input logic last);
    decode_result_t r;
    logic [6:0]     v;
    logic [11:0]    acc;
    int unsigned    n;
    r.out_byte   = '0;
    r.byte_valid = 1'b0;
    sent_chars++;
    if (!dec_halted) begin
      v = sextet_of(c);
      if (c == CharPad) begin
        dec_halted = 1'b1;
      end else if (c == CharSpace || c == CharTab || c == CharCr || c == CharLf) begin
        // skip whitespace
      end else if (v[6]) begin
        dec_status = StatusBadChar;
        dec_halted = 1'b1;
      end else begin
        acc = {dec_bits, v[5:0]};
        n = dec_nbits + 6;
        if (n >= 8) begin
          n -= 8;
          if (dec_emitted >= limit_reg || dec_emitted == 16'hFFFF) begin
            dec_status = StatusLimit;
            dec_halted = 1'b1;
          end else begin
            r.out_byte   = 8'(acc >> n);
            r.byte_valid = 1'b1;
            dec_emitted  = dec_emitted + 16'd1;
          end
        end
        dec_bits  = 6'(acc & ((12'd1 << n) - 12'd1));
        dec_nbits = 3'(n);
      end
    end
    r.frame_done = last;
    r.status     = dec_status;
    r.byte_count = dec_emitted;
    decoded_q.push_back(r);
    // the last character closes the message: clear everything but the limit
    if (last) begin
      dec_bits    = '0;
      dec_nbits   = '0;
      dec_emitted = '0;
      dec_halted  = 1'b0;
      dec_status  = StatusOk;
    end
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap(input int unsigned pct);
    int unsigned r;
    if ($urandom_range(99, 0) >= pct) return 0;
    r = $urandom_range(19, 0);
    if (r < 15) return $urandom_range(3, 1);
    if (r < 19) return $urandom_range(10, 4);
    return $urandom_range(40, 16);
  endfunction

  // Driver: hold the item until it is taken, then load the next after any gap.
  always @(posedge clk_i or negedge rst_ni) begin
    char_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) decode_char(s_axis_tdata_i, s_axis_tlast_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (char_q.size() != 0) begin
          it = char_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= it.ch;
          s_axis_tlast_i  <= it.last;
          src_gap = pick_gap(src_idle_pct);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    decode_result_t w;
    logic           bad;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (decoded_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result item: tdata %08h tuser %b tlast %b",
                     m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          mismatches++;
        end else begin
          w = decoded_q.pop_front();
          bad = 1'b0;
          if (m_axis_tdata_o[7:0] !== w.out_byte) bad = 1'b1;
          if (m_axis_tdata_o[9:8] !== w.status) bad = 1'b1;
          if (m_axis_tdata_o[25:10] !== w.byte_count) bad = 1'b1;
          if (m_axis_tdata_o[31:26] !== 6'd0) bad = 1'b1;
          if (m_axis_tuser_o !== w.byte_valid) bad = 1'b1;
          if (m_axis_tlast_o !== w.frame_done) bad = 1'b1;
          if (bad) begin
            if (mismatches < 10)
              $display({"result mismatch: want byte %02h valid %b done %b status %0d count %0d,",
                        " got byte %02h valid %b done %b status %0d count %0d pad %02h"},
                       w.out_byte, w.byte_valid, w.frame_done, w.status, w.byte_count,
                       m_axis_tdata_o[7:0], m_axis_tuser_o, m_axis_tlast_o,
                       m_axis_tdata_o[9:8], m_axis_tdata_o[25:10], m_axis_tdata_o[31:26]);
            mismatches++;
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (sink_hold) begin
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        sink_gap = pick_gap(sink_idle_pct);
      end
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering items.
  initial begin
    forever begin
      @(sink_hold_go);
      @(posedge clk_i);
      sink_hold <= 1'b1;
      repeat (SinkHoldCycles) @(posedge clk_i);
      sink_hold <= 1'b0;
    end
  end

  task automatic push_char(input logic [7:0] c, input logic last);
    char_item_t it;
    it.ch   = c;
    it.last = last;
    char_q.push_back(it);
  endtask

  task automatic push_text(input string s, input bit last_on_end);
    for (int i = 0; i < s.len(); i++) push_char(s[i], last_on_end && (i == s.len() - 1));
  endtask

  // Stall until the driver is empty and every expected result has come back.
  task automatic wait_drained();
    while (char_q.size() != 0 || s_axis_tvalid_i || decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write output_limit while the decoder is idle.
  task automatic write_limit(input logic [15:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_reg = value;
  endtask

  // One random message: mostly well-formed text with random content,
  // sometimes padded, sometimes broken by a bad character, sometimes noise.
  task automatic push_message();
    logic [7:0]  chars[$];
    logic [7:0]  c;
    int unsigned n;
    int unsigned kind;
    int unsigned ws_pct;
    bit          url;
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
    kind = $urandom_range(9, 0);
    ws_pct = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(25, 5);
    url = $urandom_range(1, 0);
    for (int i = 0; i < n; i++) begin
      if (kind == 9) begin
        chars.push_back(8'($urandom_range(255, 0)));
      end else begin
        if ($urandom_range(99, 0) < ws_pct) begin
          case ($urandom_range(3, 0))
            0: chars.push_back(CharSpace);
            1: chars.push_back(CharTab);
            2: chars.push_back(CharCr);
            default: chars.push_back(CharLf);
          endcase
        end
        if ($urandom_range(7, 0) == 0) url = ~url;
        chars.push_back(char_of(6'($urandom_range(63, 0)), url));
      end
    end
    if (kind < 3) begin
      // pad, then maybe trailing text that must be ignored
      chars.push_back(CharPad);
      if ($urandom_range(1, 0) == 0) chars.push_back(CharPad);
      repeat ($urandom_range(3, 0)) chars.push_back(8'($urandom_range(255, 0)));
    end else if (kind == 3 || kind == 4) begin
      // break the message with a non-alphabet character somewhere
      do c = 8'($urandom_range(255, 0));
      while (sextet_of(c) != 7'd64 || c == CharPad || c == CharSpace || c == CharTab ||
             c == CharCr || c == CharLf);
      chars.insert($urandom_range(chars.size(), 0), c);
    end
    foreach (chars[i]) push_char(chars[i], i == chars.size() - 1);
  endtask

  // Stimulus: directed messages, then random phases over several limits.
  initial begin
    logic [15:0] lim;
    int unsigned msgs;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain decode, both alphabets with whitespace, padding with ignored tail,
    // a bad character mid-message, trailing bits dropped, a lone bad last char
    push_text("TWFu", 1'b1);
    push_text(" \t-\r_\n+/", 1'b1);
    push_text("QQ==A!", 1'b1);
    push_char("A", 1'b0);
    push_char("z", 1'b0);
    push_char(8'h00, 1'b0);
    push_char("9", 1'b1);
    push_text("QQ", 1'b1);
    push_char(8'hFF, 1'b1);

    // limit of zero overflows on the first byte, limit of one on the second
    write_limit(16'd0);
    push_text("QUJD", 1'b1);
    write_limit(16'd1);
    push_text("QUJD", 1'b1);

    for (int phase = 0; sent_chars < CharTarget; phase++) begin
      case (phase % 8)
        0: lim = 16'hFFFF;
        1: lim = 16'd0;
        2: lim = 16'd1;
        3: lim = 16'($urandom_range(65535, 0));
        default: lim = 16'($urandom_range(24, 2));
      endcase
      write_limit(lim);
      if (phase % 4 == 1) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = $urandom_range(50, 10);
        sink_idle_pct = $urandom_range(50, 10);
      end
      // fill the decoder while the receiver holds off
      if (phase == 1) -> sink_hold_go;
      msgs = $urandom_range(24, 12);
      for (int m = 0; m < msgs; m++) begin
        push_message();
        // let the sender pause now and then until all results are back
        if ($urandom_range(9, 0) == 0) wait_drained();
        while (char_q.size() > 40) @(posedge clk_i);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("base64_stream_decoder: match");
    end else begin
      $display("base64_stream_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("base64_stream_decoder: mismatch");
    $finish;
  end

endmodule
